// ===== hdl/cbrd_pkg.sv =====
// shared types and constants for the contact block record decoder
package cbrd_pkg;

  localparam logic [4:0] PH_IDLE   = 5'd0;
  localparam logic [4:0] PH_NREC   = 5'd1;
  localparam logic [4:0] PH_LX     = 5'd2;
  localparam logic [4:0] PH_LY     = 5'd3;
  localparam logic [4:0] PH_LC     = 5'd4;
  localparam logic [4:0] PH_XOFF   = 5'd5;
  localparam logic [4:0] PH_YOFF   = 5'd6;
  localparam logic [4:0] PH_SHORT  = 5'd7;
  localparam logic [4:0] PH_TYPE   = 5'd8;
  localparam logic [4:0] PH_ROWCNT = 5'd9;
  localparam logic [4:0] PH_ROWY   = 5'd10;
  localparam logic [4:0] PH_COLCNT = 5'd11;
  localparam logic [4:0] PH_COLX   = 5'd12;
  localparam logic [4:0] PH_RCOUNT = 5'd13;
  localparam logic [4:0] PH_NPTS   = 5'd14;
  localparam logic [4:0] PH_WIDTH  = 5'd15;
  localparam logic [4:0] PH_DCOUNT = 5'd16;

  localparam logic [7:0]  LAYOUT_ROWS  = 8'd1;
  localparam logic [7:0]  LAYOUT_DENSE = 8'd2;
  localparam logic [15:0] MISSING_SHORT = 16'h8000;

  // count kinds handed from front to back
  localparam logic [1:0] CK_NONE  = 2'd0;
  localparam logic [1:0] CK_RAW   = 2'd1;
  localparam logic [1:0] CK_SHORT = 2'd2;
  localparam logic [1:0] CK_FLOAT = 2'd3;

  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  // one classified transaction from the parser
  typedef struct packed {
    logic [31:0] bin_x;
    logic [31:0] bin_y;
    logic [31:0] raw;
    logic [1:0]  kind;
    logic        dense;
    logic        last;
  } rec_t;

endpackage

// ===== hdl/contact_block_record_decoder_top.sv =====
// top level of the contact block record decoder
// Takes one inflated block byte per cycle and produces sparse records; a byte is taken every
// cycle while the four-entry queue between parser and formatter has room, and a result
// goes through the queue and the formatter's output register. The legacy_format register is
// sampled when a block's record count completes; write it only while the block is idle.
module contact_block_record_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_legacy_format,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_block_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_bin_x,
  output logic signed [31:0] out_bin_y,
  output logic [31:0] out_count_bits,
  output logic        out_present,
  output logic        out_last_of_block
);

  logic legacy_r;
  logic push, full, pop, nonempty;
  cbrd_pkg::rec_t wdata, rdata;
  logic [31:0] bx, by;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) legacy_r <= 1'b0;
    else if (cfg_valid) legacy_r <= cfg_legacy_format;
  end

  cbrd_front u_front (
    .clk(clk), .rst_n(rst_n), .legacy(legacy_r),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .in_block_start(in_block_start),
    .q_push(push), .q_data(wdata), .q_full(full));

  cbrd_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(wdata), .full(full),
    .pop(pop), .nonempty(nonempty), .rdata(rdata));

  cbrd_back u_back (
    .clk(clk), .rst_n(rst_n), .q_nonempty(nonempty), .q_data(rdata), .q_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_bin_x(bx), .out_bin_y(by), .out_count_bits(out_count_bits),
    .out_present(out_present), .out_last_of_block(out_last_of_block));

  assign out_bin_x = signed'(bx);
  assign out_bin_y = signed'(by);

endmodule

// ===== hdl/cbrd_front.sv =====
// byte parser: gathers fields, tracks layout counters and emits raw records
module cbrd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              legacy,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              in_block_start,
  output logic              q_push,
  output cbrd_pkg::rec_t    q_data,
  input  logic              q_full
);

  logic [4:0]  phase_r, phase_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] xoff_r, xoff_nxt, yoff_r, yoff_nxt;
  logic        short_r, short_nxt;
  logic [31:0] recs_r, recs_nxt;
  logic [15:0] rows_r, rows_nxt, cols_r, cols_nxt;
  logic [31:0] row_r, row_nxt, col_r, col_nxt;
  logic [15:0] dw_r, dw_nxt, dcol_r, dcol_nxt;

  logic        go;
  logic [4:0]  ph;
  logic [1:0]  cb;
  logic [31:0] sh, v;
  logic [1:0]  cl;
  logic        done, rec;
  logic [15:0] rows_dec, dcol_inc;

  assign in_stall = q_full;
  assign go = in_valid && !q_full;

  function automatic logic np16(input logic [15:0] a);
    return (a == 16'd0) || a[15];
  endfunction

  always_comb begin
    phase_nxt = phase_r; shift_nxt = shift_r; cnt_nxt = cnt_r;
    xoff_nxt = xoff_r; yoff_nxt = yoff_r; short_nxt = short_r;
    recs_nxt = recs_r; rows_nxt = rows_r; cols_nxt = cols_r;
    row_nxt = row_r; col_nxt = col_r; dw_nxt = dw_r; dcol_nxt = dcol_r;
    done = 1'b0; rec = 1'b0;
    q_data = '0;
    ph = in_block_start ? cbrd_pkg::PH_NREC : phase_r;
    sh = in_block_start ? 32'd0 : shift_r;
    cb = in_block_start ? 2'd0 : cnt_r;
    v = sh | ({24'd0, in_byte} << {cb, 3'b000});
    rows_dec = rows_r - 16'd1;
    dcol_inc = dcol_r + 16'd1;
    case (ph)
      cbrd_pkg::PH_SHORT, cbrd_pkg::PH_TYPE: cl = 2'd1;
      cbrd_pkg::PH_ROWCNT, cbrd_pkg::PH_ROWY, cbrd_pkg::PH_COLCNT,
      cbrd_pkg::PH_COLX, cbrd_pkg::PH_WIDTH: cl = 2'd2;
      cbrd_pkg::PH_RCOUNT, cbrd_pkg::PH_DCOUNT: cl = short_r ? 2'd2 : 2'd0;
      default: cl = 2'd0;
    endcase
    if (ph != cbrd_pkg::PH_IDLE && ph <= cbrd_pkg::PH_DCOUNT) begin
      if (cb + 2'd1 == cl) begin
        shift_nxt = 32'd0; cnt_nxt = 2'd0;
        case (ph)
          cbrd_pkg::PH_NREC: begin
            if (legacy) begin
              if (v == 32'd0 || v[31]) begin
                phase_nxt = cbrd_pkg::PH_IDLE; done = 1'b1;
              end else begin
                recs_nxt = v; phase_nxt = cbrd_pkg::PH_LX;
              end
            end else phase_nxt = cbrd_pkg::PH_XOFF;
          end
          cbrd_pkg::PH_LX: begin col_nxt = v; phase_nxt = cbrd_pkg::PH_LY; end
          cbrd_pkg::PH_LY: begin row_nxt = v; phase_nxt = cbrd_pkg::PH_LC; end
          cbrd_pkg::PH_LC: begin
            rec = 1'b1;
            q_data.bin_x = col_r; q_data.bin_y = row_r; q_data.raw = v;
            q_data.kind = cbrd_pkg::CK_RAW;
            recs_nxt = recs_r - 32'd1;
            if (recs_r == 32'd1) begin
              phase_nxt = cbrd_pkg::PH_IDLE; done = 1'b1;
            end else phase_nxt = cbrd_pkg::PH_LX;
          end
          cbrd_pkg::PH_XOFF: begin xoff_nxt = v; phase_nxt = cbrd_pkg::PH_YOFF; end
          cbrd_pkg::PH_YOFF: begin yoff_nxt = v; phase_nxt = cbrd_pkg::PH_SHORT; end
          cbrd_pkg::PH_SHORT: begin
            short_nxt = (v[7:0] == 8'd0); phase_nxt = cbrd_pkg::PH_TYPE;
          end
          cbrd_pkg::PH_TYPE: begin
            if (v[7:0] == cbrd_pkg::LAYOUT_ROWS) phase_nxt = cbrd_pkg::PH_ROWCNT;
            else if (v[7:0] == cbrd_pkg::LAYOUT_DENSE) phase_nxt = cbrd_pkg::PH_NPTS;
            else begin phase_nxt = cbrd_pkg::PH_IDLE; done = 1'b1; end
          end
          cbrd_pkg::PH_ROWCNT: begin
            if (np16(v[15:0])) begin phase_nxt = cbrd_pkg::PH_IDLE; done = 1'b1; end
            else begin rows_nxt = v[15:0]; phase_nxt = cbrd_pkg::PH_ROWY; end
          end
          cbrd_pkg::PH_ROWY: begin
            row_nxt = yoff_r + {{16{v[15]}}, v[15:0]}; phase_nxt = cbrd_pkg::PH_COLCNT;
          end
          cbrd_pkg::PH_COLCNT: begin
            if (np16(v[15:0])) begin
              rows_nxt = rows_dec;
              if (rows_dec == 16'd0) begin phase_nxt = cbrd_pkg::PH_IDLE; done = 1'b1; end
              else phase_nxt = cbrd_pkg::PH_ROWY;
            end else begin cols_nxt = v[15:0]; phase_nxt = cbrd_pkg::PH_COLX; end
          end
          cbrd_pkg::PH_COLX: begin
            col_nxt = xoff_r + {{16{v[15]}}, v[15:0]}; phase_nxt = cbrd_pkg::PH_RCOUNT;
          end
          cbrd_pkg::PH_RCOUNT: begin
            rec = 1'b1;
            q_data.bin_x = col_r; q_data.bin_y = row_r; q_data.raw = v;
            q_data.kind = short_r ? cbrd_pkg::CK_SHORT : cbrd_pkg::CK_RAW;
            cols_nxt = cols_r - 16'd1;
            if (cols_r == 16'd1) begin
              rows_nxt = rows_dec;
              if (rows_dec == 16'd0) begin phase_nxt = cbrd_pkg::PH_IDLE; done = 1'b1; end
              else phase_nxt = cbrd_pkg::PH_ROWY;
            end else phase_nxt = cbrd_pkg::PH_COLX;
          end
          cbrd_pkg::PH_NPTS: begin recs_nxt = v; phase_nxt = cbrd_pkg::PH_WIDTH; end
          cbrd_pkg::PH_WIDTH: begin
            dw_nxt = np16(v[15:0]) ? 16'd1 : v[15:0];
            dcol_nxt = 16'd0; row_nxt = yoff_r;
            if (recs_r == 32'd0 || recs_r[31]) begin
              phase_nxt = cbrd_pkg::PH_IDLE; done = 1'b1;
            end else phase_nxt = cbrd_pkg::PH_DCOUNT;
          end
          cbrd_pkg::PH_DCOUNT: begin
            rec = 1'b1;
            q_data.bin_x = xoff_r + {16'd0, dcol_r}; q_data.bin_y = row_r;
            q_data.raw = v; q_data.dense = 1'b1;
            q_data.kind = short_r ? cbrd_pkg::CK_SHORT : cbrd_pkg::CK_FLOAT;
            if (dcol_inc >= dw_r) begin
              dcol_nxt = 16'd0; row_nxt = row_r + 32'd1;
            end else dcol_nxt = dcol_inc;
            recs_nxt = recs_r - 32'd1;
            if (recs_r == 32'd1) begin phase_nxt = cbrd_pkg::PH_IDLE; done = 1'b1; end
          end
          default: phase_nxt = cbrd_pkg::PH_IDLE;
        endcase
      end else begin
        shift_nxt = v; cnt_nxt = cb + 2'd1; phase_nxt = ph;
      end
    end else begin
      phase_nxt = cbrd_pkg::PH_IDLE; shift_nxt = sh; cnt_nxt = cb;
    end
    q_data.last = done;
  end

  assign q_push = go && (rec || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cbrd_pkg::PH_IDLE; shift_r <= '0; cnt_r <= '0;
      xoff_r <= '0; yoff_r <= '0; short_r <= 1'b0; recs_r <= '0;
      rows_r <= '0; cols_r <= '0; row_r <= '0; col_r <= '0;
      dw_r <= '0; dcol_r <= '0;
    end else if (go) begin
      phase_r <= phase_nxt; shift_r <= shift_nxt; cnt_r <= cnt_nxt;
      xoff_r <= xoff_nxt; yoff_r <= yoff_nxt; short_r <= short_nxt;
      recs_r <= recs_nxt; rows_r <= rows_nxt; cols_r <= cols_nxt;
      row_r <= row_nxt; col_r <= col_nxt; dw_r <= dw_nxt; dcol_r <= dcol_nxt;
    end
  end

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> in_stall) else $error("front took a byte into a full queue");
  a_push_go: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> go) else $error("push without an accepted byte");
  a_idle_next: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_data.last) |=> (phase_r == cbrd_pkg::PH_IDLE))
    else $error("block ended but parser not idle");

endmodule

// ===== hdl/cbrd_queue.sv =====
// small fifo between the parser and the record formatter
module cbrd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cbrd_pkg::rec_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output cbrd_pkg::rec_t rdata
);

  cbrd_pkg::rec_t mem [cbrd_pkg::QDEPTH];
  logic [cbrd_pkg::QAW-1:0] wp_r, rp_r;
  logic [cbrd_pkg::QAW:0]   n_r;

  assign full = (n_r == cbrd_pkg::QAW'(0) + (cbrd_pkg::QAW+1)'(cbrd_pkg::QDEPTH));
  assign nonempty = (n_r != '0);
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; n_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      n_r <= n_r + (cbrd_pkg::QAW+1)'(push) - (cbrd_pkg::QAW+1)'(pop);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    !nonempty |-> !pop) else $error("queue underflow");

endmodule

// ===== hdl/cbrd_back.sv =====
// record formatter: short-to-float conversion, missing markers, output register
module cbrd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_nonempty,
  input  cbrd_pkg::rec_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [31:0]    out_bin_x,
  output logic [31:0]    out_bin_y,
  output logic [31:0]    out_count_bits,
  output logic           out_present,
  output logic           out_last_of_block
);

  logic        vld_r;
  logic [31:0] x_r, y_r, c_r;
  logic        p_r, l_r;
  logic [31:0] cnt;
  logic        pres;
  logic [15:0] s, mag;
  logic [3:0]  e;
  logic [31:0] fl;
  logic        nan;

  assign q_pop = q_nonempty && (!vld_r || !out_stall);

  always_comb begin
    s = q_data.raw[15:0];
    mag = s[15] ? (16'd0 - s) : s;
    e = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if (mag[i]) e = 4'(i);
    end
    // 0x8000 negates to 0x8000, treated as magnitude 2^15
    fl = {s[15], 8'(8'd127 + {4'd0, e}), 23'(({7'd0, mag} << (5'd23 - {1'b0, e})))};
    if (s == 16'd0) fl = 32'd0;
    nan = (q_data.raw[30:23] == 8'hff) && (q_data.raw[22:0] != 23'd0);
    pres = 1'b1; cnt = q_data.raw;
    case (q_data.kind)
      cbrd_pkg::CK_NONE: begin pres = 1'b0; cnt = 32'd0; end
      cbrd_pkg::CK_RAW: cnt = q_data.raw;
      cbrd_pkg::CK_SHORT: begin
        pres = !(q_data.dense && s == cbrd_pkg::MISSING_SHORT);
        cnt = pres ? fl : 32'd0;
      end
      cbrd_pkg::CK_FLOAT: begin pres = !nan; cnt = pres ? q_data.raw : 32'd0; end
      default: cnt = q_data.raw;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (q_pop) vld_r <= 1'b1;
    else if (!out_stall) vld_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_r <= q_data.bin_x; y_r <= q_data.bin_y; c_r <= cnt;
      p_r <= pres; l_r <= q_data.last;
    end
  end

  assign out_valid = vld_r;
  assign out_bin_x = x_r;
  assign out_bin_y = y_r;
  assign out_count_bits = c_r;
  assign out_present = p_r;
  assign out_last_of_block = l_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && out_stall) |=> vld_r) else $error("result dropped under stall");
  a_nopop: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && out_stall) |-> !q_pop) else $error("overwrote stalled result");
  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !p_r) |-> (c_r == 32'd0)) else $error("absent record with count");

endmodule

// ===== sim/contact_block_record_decoder_checker.sv =====
// checker: predicts decoder records from accepted bytes and compares them
`timescale 1ns / 1ps
module contact_block_record_decoder_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_legacy_format,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_block_start,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_bin_x,
  input  logic [31:0] out_bin_y,
  input  logic [31:0] out_count_bits,
  input  logic        out_present,
  input  logic        out_last_of_block,
  output int          fail_count,
  output int          pending_records,
  output int          records_seen
);

  typedef struct packed {
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] cnt;
    logic        pres;
    logic        last;
  } record_t;

  record_t expected_records[$];

  logic        legacy_q;
  logic [4:0]  phase;
  logic [31:0] shreg;
  logic [1:0]  nbytes;
  logic [31:0] xoff, yoff, recs_left, row_bin, col_bin;
  logic        short_cnt;
  logic [15:0] rows_left, cols_left, dwidth, dcol;

  assign pending_records = expected_records.size();

  function automatic logic [31:0] short_float(logic [15:0] v);
    logic [16:0] mag;
    logic [31:0] sgn;
    int e;
    if (v == 16'd0) return 32'd0;
    sgn = v[15] ? 32'h8000_0000 : 32'd0;
    mag = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
    e = 0;
    for (int i = 0; i < 17; i++) if (mag[i]) e = i;
    return sgn | ((32'(127 + e)) << 23) | ((32'(mag) << (23 - e)) & 32'h7f_ffff);
  endfunction

  function automatic logic [31:0] sx16(logic [31:0] v);
    return {{16{v[15]}}, v[15:0]};
  endfunction

  function automatic logic np16(logic [31:0] v);
    return v[15:0] == 16'd0 || v[15];
  endfunction

  function automatic logic np32(logic [31:0] v);
    return v == 32'd0 || v[31];
  endfunction

  // shift one byte into the current field; returns 1 when n bytes are in
  task automatic take_byte(input logic [7:0] b, input int n, output logic full,
                           output logic [31:0] val);
    logic [31:0] s;
    s = shreg | (32'(b) << (8 * nbytes));
    nbytes = nbytes + 2'd1;
    full = (nbytes == 2'(n));
    val = s;
    shreg = full ? 32'd0 : s;
    if (full) nbytes = 2'd0;
  endtask

  task automatic row_done(inout logic done);
    rows_left = rows_left - 16'd1;
    if (rows_left == 16'd0) begin
      phase = cbrd_pkg::PH_IDLE;
      done = 1'b1;
    end else phase = cbrd_pkg::PH_ROWY;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic bs);
    logic full, done, rec, pres;
    logic [31:0] v, rx, ry, rc;
    record_t r;
    done = 0; rec = 0; pres = 0; rx = 0; ry = 0; rc = 0; v = 0; full = 0;
    if (bs) begin
      phase = cbrd_pkg::PH_NREC; shreg = 0; nbytes = 0;
    end
    case (phase)
      cbrd_pkg::PH_NREC: begin
        take_byte(b, 4, full, v);
        if (full) begin
          if (legacy_q) begin
            if (np32(v)) begin phase = cbrd_pkg::PH_IDLE; done = 1; end
            else begin recs_left = v; phase = cbrd_pkg::PH_LX; end
          end else phase = cbrd_pkg::PH_XOFF;
        end
      end
      cbrd_pkg::PH_LX: begin
        take_byte(b, 4, full, v);
        if (full) begin col_bin = v; phase = cbrd_pkg::PH_LY; end
      end
      cbrd_pkg::PH_LY: begin
        take_byte(b, 4, full, v);
        if (full) begin row_bin = v; phase = cbrd_pkg::PH_LC; end
      end
      cbrd_pkg::PH_LC: begin
        take_byte(b, 4, full, v);
        if (full) begin
          rec = 1; pres = 1; rx = col_bin; ry = row_bin; rc = v;
          recs_left = recs_left - 1;
          if (recs_left == 0) begin phase = cbrd_pkg::PH_IDLE; done = 1; end
          else phase = cbrd_pkg::PH_LX;
        end
      end
      cbrd_pkg::PH_XOFF: begin
        take_byte(b, 4, full, v);
        if (full) begin xoff = v; phase = cbrd_pkg::PH_YOFF; end
      end
      cbrd_pkg::PH_YOFF: begin
        take_byte(b, 4, full, v);
        if (full) begin yoff = v; phase = cbrd_pkg::PH_SHORT; end
      end
      cbrd_pkg::PH_SHORT: begin
        take_byte(b, 1, full, v);
        if (full) begin short_cnt = (v == 0); phase = cbrd_pkg::PH_TYPE; end
      end
      cbrd_pkg::PH_TYPE: begin
        take_byte(b, 1, full, v);
        if (full) begin
          if (v[7:0] == cbrd_pkg::LAYOUT_ROWS) phase = cbrd_pkg::PH_ROWCNT;
          else if (v[7:0] == cbrd_pkg::LAYOUT_DENSE) phase = cbrd_pkg::PH_NPTS;
          else begin phase = cbrd_pkg::PH_IDLE; done = 1; end
        end
      end
      cbrd_pkg::PH_ROWCNT: begin
        take_byte(b, 2, full, v);
        if (full) begin
          if (np16(v)) begin phase = cbrd_pkg::PH_IDLE; done = 1; end
          else begin rows_left = v[15:0]; phase = cbrd_pkg::PH_ROWY; end
        end
      end
      cbrd_pkg::PH_ROWY: begin
        take_byte(b, 2, full, v);
        if (full) begin row_bin = yoff + sx16(v); phase = cbrd_pkg::PH_COLCNT; end
      end
      cbrd_pkg::PH_COLCNT: begin
        take_byte(b, 2, full, v);
        if (full) begin
          if (np16(v)) row_done(done);
          else begin cols_left = v[15:0]; phase = cbrd_pkg::PH_COLX; end
        end
      end
      cbrd_pkg::PH_COLX: begin
        take_byte(b, 2, full, v);
        if (full) begin col_bin = xoff + sx16(v); phase = cbrd_pkg::PH_RCOUNT; end
      end
      cbrd_pkg::PH_RCOUNT: begin
        take_byte(b, short_cnt ? 2 : 4, full, v);
        if (full) begin
          rec = 1; pres = 1; rx = col_bin; ry = row_bin;
          rc = short_cnt ? short_float(v[15:0]) : v;
          cols_left = cols_left - 16'd1;
          if (cols_left == 0) row_done(done);
          else phase = cbrd_pkg::PH_COLX;
        end
      end
      cbrd_pkg::PH_NPTS: begin
        take_byte(b, 4, full, v);
        if (full) begin recs_left = v; phase = cbrd_pkg::PH_WIDTH; end
      end
      cbrd_pkg::PH_WIDTH: begin
        take_byte(b, 2, full, v);
        if (full) begin
          dwidth = np16(v) ? 16'd1 : v[15:0];
          dcol = 0;
          row_bin = yoff;
          if (np32(recs_left)) begin phase = cbrd_pkg::PH_IDLE; done = 1; end
          else phase = cbrd_pkg::PH_DCOUNT;
        end
      end
      cbrd_pkg::PH_DCOUNT: begin
        take_byte(b, short_cnt ? 2 : 4, full, v);
        if (full) begin
          rec = 1; rx = xoff + 32'(dcol); ry = row_bin;
          if (short_cnt) begin
            pres = v[15:0] != cbrd_pkg::MISSING_SHORT;
            rc = pres ? short_float(v[15:0]) : 0;
          end else begin
            // nan: all-ones exponent with nonzero fraction
            pres = !(v[30:23] == 8'hff && v[22:0] != 0);
            rc = pres ? v : 0;
          end
          dcol = dcol + 16'd1;
          if (dcol >= dwidth) begin dcol = 0; row_bin = row_bin + 1; end
          recs_left = recs_left - 1;
          if (recs_left == 0) begin phase = cbrd_pkg::PH_IDLE; done = 1; end
        end
      end
      default: phase = cbrd_pkg::PH_IDLE;
    endcase
    if (rec || done) begin
      r.bx = rec ? rx : 0;
      r.by = rec ? ry : 0;
      r.cnt = rec ? rc : 0;
      r.pres = rec && pres;
      r.last = done;
      expected_records.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    record_t e;
    if (!rst_n) begin
      legacy_q <= 0; phase <= cbrd_pkg::PH_IDLE; shreg <= 0; nbytes <= 0;
      xoff <= 0; yoff <= 0; short_cnt <= 0; recs_left <= 0; rows_left <= 0;
      cols_left <= 0; row_bin <= 0; col_bin <= 0; dwidth <= 0; dcol <= 0;
      fail_count <= 0; records_seen <= 0;
      expected_records.delete();
    end else begin
      if (cfg_valid && cfg_ready) legacy_q = cfg_legacy_format;
      if (in_valid && !in_stall) decode_byte(in_byte, in_block_start);
      if (out_valid && !out_stall) begin
        records_seen <= records_seen + 1;
        if (expected_records.size() == 0) begin
          $display("%0t: unexpected record x=%h y=%h c=%h p=%b l=%b", $time,
                   out_bin_x, out_bin_y, out_count_bits, out_present, out_last_of_block);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_records.pop_front();
          if ({out_bin_x, out_bin_y, out_count_bits, out_present, out_last_of_block} !== e) begin
            $display("%0t: mismatch expected x=%h y=%h c=%h p=%b l=%b", $time,
                     e.bx, e.by, e.cnt, e.pres, e.last);
            $display("%0t:          actual   x=%h y=%h c=%h p=%b l=%b", $time,
                     out_bin_x, out_bin_y, out_count_bits, out_present, out_last_of_block);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== sim/contact_block_record_decoder_top_test.sv =====
// testbench top: drives block bytes and configuration, reports the verdict
`timescale 1ns / 1ps
module contact_block_record_decoder_top_test;

  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0, cfg_legacy_format = 0, cfg_ready;
  logic in_valid = 0, in_block_start = 0, in_stall;
  logic [7:0] in_byte = 0;
  logic out_valid, out_stall = 0;
  logic signed [31:0] out_bin_x, out_bin_y;
  logic [31:0] out_count_bits;
  logic out_present, out_last_of_block;
  int fail_count, pending_records, records_seen;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int bytes_sent = 0, blocks_sent = 0, idle_cycles = 0;
  logic legacy_mode = 0;
  logic [7:0] block_bytes[$];

  always #10 clk = ~clk;

  contact_block_record_decoder_top uut (.*);

  contact_block_record_decoder_checker chk (.*);

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d records pending", pending_records);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic put_bytes(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) block_bytes.push_back(v[8*i +: 8]);
  endtask

  // send queued bytes; first one carries block_start unless raw noise
  task automatic send_block(input logic mark);
    logic first;
    first = mark;
    while (block_bytes.size() > 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 0;
        @(posedge clk);
      end
      in_valid <= 1;
      in_byte <= block_bytes.pop_front();
      in_block_start <= first;
      first = 0;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      bytes_sent++;
    end
    in_valid <= 0;
    in_block_start <= 0;
    blocks_sent++;
  endtask

  task automatic drain_and_config(input logic val);
    while (pending_records != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1;
    cfg_legacy_format <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    legacy_mode = val;
  endtask

  function automatic logic [31:0] rand_count(logic is_short);
    int k;
    k = $urandom_range(9);
    if (is_short) begin
      case (k)
        0: return 32'(cbrd_pkg::MISSING_SHORT);
        1: return 0;
        2: return 16'hffff;
        3: return 16'h7fff;
        default: return $urandom_range(16'hffff);
      endcase
    end
    case (k)
      0: return 32'h7fc00000;
      1: return 32'h7f800000;
      2: return 32'hff800001;
      3: return 32'h7f800000 | $urandom_range(32'h7fffff);
      default: return $urandom;
    endcase
  endfunction

  task automatic build_legacy(input int nrec);
    put_bytes(nrec, 4);
    for (int i = 0; i < nrec && i < 8; i++) begin
      put_bytes($urandom, 4); put_bytes($urandom, 4); put_bytes($urandom, 4);
    end
  endtask

  task automatic build_rows(input logic [7:0] shortf, input int nrows);
    logic is_short;
    int ncol;
    is_short = (shortf == 0);
    put_bytes($urandom, 4); put_bytes($urandom, 4);
    put_bytes(shortf, 1); put_bytes(cbrd_pkg::LAYOUT_ROWS, 1);
    put_bytes(nrows, 2);
    for (int r = 0; r < nrows && r < 4; r++) begin
      put_bytes($urandom, 2);
      ncol = ($urandom_range(5) == 0) ? ($urandom_range(1) ? 0 : 16'h8000 | $urandom)
                                      : $urandom_range(1, 4);
      put_bytes(ncol, 2);
      if (ncol > 0 && ncol < 16'h8000)
        for (int c = 0; c < ncol; c++) begin
          put_bytes($urandom, 2);
          put_bytes(rand_count(is_short), is_short ? 2 : 4);
        end
    end
  endtask

  task automatic build_dense(input logic [7:0] shortf, input int npts, input int width);
    logic is_short;
    is_short = (shortf == 0);
    put_bytes($urandom, 4); put_bytes($urandom, 4);
    put_bytes(shortf, 1); put_bytes(cbrd_pkg::LAYOUT_DENSE, 1);
    put_bytes(npts, 4); put_bytes(width, 2);
    for (int i = 0; i < npts && i < 12; i++) put_bytes(rand_count(is_short), is_short ? 2 : 4);
  endtask

  task automatic random_block();
    int k;
    logic [7:0] sf;
    k = $urandom_range(19);
    sf = $urandom_range(1) ? 8'd0 : 8'($urandom_range(1, 255));
    if (legacy_mode) begin
      build_legacy(k == 0 ? 0 : $urandom_range(1, 5));
    end else if (k < 8) begin
      build_rows(sf, $urandom_range(1, 3));
    end else if (k < 16) begin
      build_dense(sf, $urandom_range(1, 10), k == 8 ? 0 : (k == 9 ? 16'h8000 : $urandom_range(1, 4)));
    end else if (k == 16) begin
      put_bytes($urandom, 4); put_bytes($urandom, 4); put_bytes(sf, 1);
      put_bytes($urandom_range(3, 255), 1);
    end else if (k == 17) begin
      build_rows(sf, 0);
    end else begin
      // truncated block, cut short by the next block_start
      build_dense(sf, 8, 2);
      repeat ($urandom_range(1, 12)) void'(block_bytes.pop_back());
    end
    // truncated blocks never end; any block may get one stray byte appended after it
    if ($urandom_range(9) == 0) block_bytes.push_back($urandom);
    send_block(1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: bytes outside a block, legacy empty and full, all layouts
    block_bytes.push_back(8'hff); block_bytes.push_back(8'h00); send_block(0);
    drain_and_config(1);
    build_legacy(0); send_block(1);
    put_bytes(32'h8000_0000, 4); send_block(1);
    block_bytes.push_back(8'h01); block_bytes.push_back(8'h02); send_block(1);  // dropped
    build_legacy(2); send_block(1);
    drain_and_config(0);
    put_bytes(32'hffff_ffff, 4); put_bytes(32'h7fff_ffff, 4); put_bytes(8'd0, 1);
    put_bytes(cbrd_pkg::LAYOUT_ROWS, 1); put_bytes(2, 2);
    put_bytes(16'h8000, 2); put_bytes(1, 2); put_bytes(16'hffff, 2); put_bytes(16'h8000, 2);
    put_bytes(16'h7fff, 2); put_bytes(0, 2);
    send_block(1);
    build_dense(8'd0, 4, 0); send_block(1);
    build_dense(8'd255, 3, 2); send_block(1);
    build_dense(8'd1, 0, 3); send_block(1);
    put_bytes(0, 4); put_bytes(0, 4); put_bytes(0, 1); put_bytes(8'd0, 1); send_block(1);

    for (int phase_no = 0; phase_no < 3; phase_no++) begin
      send_idle_pct = (phase_no == 0) ? 32 : (phase_no == 1 ? 57 : 0);
      recv_idle_pct = (phase_no == 0) ? 57 : (phase_no == 1 ? 32 : 0);
      for (int seg = 0; seg < 4; seg++) begin
        drain_and_config(seg == 1);
        repeat (6) random_block();
      end
      while (bytes_sent < (phase_no + 1) * 300) random_block();
    end

    while (pending_records != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d bytes in %0d blocks, checked %0d records", bytes_sent, blocks_sent,
             records_seen);
    $display("covered legacy, row-list and dense layouts under three idle patterns");
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
